@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check that is held off during reset.
`define ODO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("odometry check failed");
// Clocked check that also holds during reset.
`define ODO_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("odometry check failed");
`else
`define ODO_ASSERT(lbl, prop)
`define ODO_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ design/ddo_pkg.sv @@
// ---------------------------------------------------------------------------
// Differential drive odometry package
// Fixed point angle constants, defaults, register indexes and the arctangent
// table of the CORDIC rotator.
// ---------------------------------------------------------------------------
package ddo_pkg;

  // Default build settings.
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;

  // Angles are signed Q2.29, quaternion parts signed Q1.30.
  localparam int ANG_FRAC = 29;
  localparam logic [31:0] PI_Q      = 32'd1686629713;
  localparam logic [31:0] TWO_PI_Q  = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q = 32'd843314857;
  localparam logic [31:0] GAIN_Q30  = 32'd652032874;
  localparam logic [31:0] ONE_Q30   = 32'd1073741824;

  // Configuration register reset values.
  localparam logic [31:0] CPM_RESET = 32'd65536000;
  localparam logic [31:0] WS_RESET  = 32'd19661;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_METER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SPACING    = 2'd1;

  localparam int ATAN_IDX_W = 5;

  // Arctangent of 2^-i in Q2.29.
  function automatic logic [31:0] atan_q29(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd421657428;
      5'd1:  v = 32'd248918915;
      5'd2:  v = 32'd131521918;
      5'd3:  v = 32'd66762579;
      5'd4:  v = 32'd33510843;
      5'd5:  v = 32'd16771758;
      5'd6:  v = 32'd8387925;
      5'd7:  v = 32'd4194219;
      5'd8:  v = 32'd2097141;
      5'd9:  v = 32'd1048575;
      5'd10: v = 32'd524288;
      5'd11: v = 32'd262144;
      5'd12: v = 32'd131072;
      5'd13: v = 32'd65536;
      5'd14: v = 32'd32768;
      5'd15: v = 32'd16384;
      5'd16: v = 32'd8192;
      5'd17: v = 32'd4096;
      5'd18: v = 32'd2048;
      5'd19: v = 32'd1024;
      5'd20: v = 32'd512;
      5'd21: v = 32'd256;
      5'd22: v = 32'd128;
      5'd23: v = 32'd64;
      5'd24: v = 32'd32;
      5'd25: v = 32'd16;
      5'd26: v = 32'd8;
      5'd27: v = 32'd4;
      5'd28: v = 32'd2;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/diff_drive_odometry_top.sv @@
// ---------------------------------------------------------------------------
// Differential drive odometry
// Integrates wheel encoder counts into a planar pose and yaw quaternion.
// ---------------------------------------------------------------------------
// One transaction on the input channel carries a pair of absolute encoder
// counts; the block answers with one transaction holding position (Q16.16),
// heading (Q2.29, wrapped to +-pi) and the yaw quaternion (Q1.30). All
// arithmetic runs on one bit-serial restoring divider, one CORDIC rotator and
// one 32x32 multiplier under a small sequencer, and the input stalls while an
// item is in work. With a nonzero right count an item runs the left and right
// wheel divisions, the heading division and the CORDIC passes; with a right
// count of zero the two wheel divisions are skipped. The divider's one
// quotient bit per cycle sets most of an item's run time. A finished result
// waits in the output register, so the next item may be accepted before it is
// taken.
`include "assert_macros.svh"

module diff_drive_odometry_top #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = ddo_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            left_count,
  input  logic signed [31:0]            right_count,
  // Output channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            pos_x,
  output logic signed [31:0]            pos_y,
  output logic signed [31:0]            heading,
  output logic signed [31:0]            quat_z,
  output logic signed [31:0]            quat_w
);
  import ddo_pkg::*;

  localparam int TRV_STEPS = 33 + 2 * FRAC_BITS;
  localparam int TH_STEPS  = 33 + ANG_FRAC;
  localparam int MAX_STEPS = (TRV_STEPS > TH_STEPS) ? TRV_STEPS : TH_STEPS;
  localparam int CNT_W     = $clog2(MAX_STEPS);
  localparam int IDX_W     = $clog2(CORDIC_STEPS);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_DIV_L  = 11'b00000000010,
    ST_DIV_R  = 11'b00000000100,
    ST_SUM    = 11'b00000001000,
    ST_DIV_TH = 11'b00000010000,
    ST_LOAD   = 11'b00000100000,
    ST_COR    = 11'b00001000000,
    ST_MUL_X  = 11'b00010000000,
    ST_MUL_Y  = 11'b00100000000,
    ST_ADD_Y  = 11'b01000000000,
    ST_OUT    = 11'b10000000000
  } state_t;

  state_t state;

  // Configuration and pose state.
  logic [31:0]        cpm, ws;
  logic [31:0]        last_left, last_right;
  logic [31:0]        acc_x, acc_y;
  logic signed [31:0] acc_heading;

  // Divider registers.
  logic [32:0]      mag;
  logic             neg;
  logic [31:0]      dvs;
  logic [31:0]      rem;
  logic [31:0]      quo;
  logic             ovf;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      dr;

  // Step values.
  logic signed [31:0] tl, tr, fwd, dth;

  // CORDIC registers.
  logic signed [33:0] cx, cy, cz;
  logic               flip;
  logic               second;
  logic [IDX_W-1:0]   idx;
  logic signed [31:0] cos_r, sin_r;
  logic [31:0]        prod_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [33:0] one;
    one = $signed({2'b00, ONE_Q30});
    if (v > one) return $signed(ONE_Q30);
    if (v < -one) return -$signed(ONE_Q30);
    return v[31:0];
  endfunction

  // Wrap a value within two turns back into [-pi, pi].
  function automatic logic signed [31:0] wrap_ang(input logic signed [33:0] a);
    logic signed [33:0] v;
    v = a;
    if (v > $signed({2'b00, PI_Q})) v = v - $signed({2'b00, TWO_PI_Q});
    if (v < -$signed({2'b00, PI_Q})) v = v + $signed({2'b00, TWO_PI_Q});
    return v[31:0];
  endfunction

  // Count deltas, modulo 2^32.
  logic [31:0] dl_in, dr_in;
  assign dl_in = left_count - last_left;
  assign dr_in = right_count - last_right;

  // Shared restoring divider: one quotient bit per cycle.
  logic [32:0] div_part;
  logic        div_ge;
  logic [31:0] rem_next, quo_next;
  logic        ovf_next;
  logic [32:0] mod_part;
  logic [31:0] trv_res;

  always_comb begin
    div_part = {rem, mag[32]};
    div_ge   = (div_part >= {1'b0, dvs});
    rem_next = div_ge ? 32'(div_part - {1'b0, dvs}) : div_part[31:0];
    mod_part = {quo, div_ge};
    if (state == ST_DIV_TH) begin
      quo_next = (mod_part >= {1'b0, TWO_PI_Q}) ? 32'(mod_part - {1'b0, TWO_PI_Q})
                                                : mod_part[31:0];
      ovf_next = 1'b0;
    end else begin
      quo_next = {quo[30:0], div_ge};
      ovf_next = ovf | quo[30];
    end
    trv_res = ovf_next ? 32'h7FFF_FFFF : {1'b0, quo_next[30:0]};
    if (neg) trv_res = -trv_res;
  end

  // Forward step and heading difference from the two travels.
  logic signed [32:0] sum33, diff33;
  logic signed [32:0] fwd33;
  always_comb begin
    sum33  = {tl[31], tl} + {tr[31], tr};
    fwd33  = (sum33 + {32'd0, sum33[32]}) >>> 1;
    diff33 = {tl[31], tl} - {tr[31], tr};
  end

  // Heading step after the modulo, signed and wrapped.
  logic signed [33:0] dth_raw;
  always_comb begin
    dth_raw = $signed({2'b00, quo_next});
    if (neg) dth_raw = -dth_raw;
  end

  // CORDIC start angle with the half-turn fold.
  logic signed [33:0] ang, z0;
  logic               flip0;
  always_comb begin
    ang = second ? {{2{acc_heading[31]}}, acc_heading >>> 1}
                 : {{2{acc_heading[31]}}, acc_heading};
    z0    = ang;
    flip0 = 1'b0;
    if (ang > $signed({2'b00, HALF_PI_Q})) begin
      z0    = ang - $signed({2'b00, PI_Q});
      flip0 = 1'b1;
    end else if (ang < -$signed({2'b00, HALF_PI_Q})) begin
      z0    = ang + $signed({2'b00, PI_Q});
      flip0 = 1'b1;
    end
  end

  // One CORDIC rotation step.
  logic signed [33:0] cx_next, cy_next, cz_next, sx, sy, at;
  always_comb begin
    sx = cx >>> idx;
    sy = cy >>> idx;
    at = $signed({2'b00, atan_q29(ATAN_IDX_W'(idx))});
    if (cz >= 0) begin
      cx_next = cx - sy;
      cy_next = cy + sx;
      cz_next = cz - at;
    end else begin
      cx_next = cx + sy;
      cy_next = cy - sx;
      cz_next = cz + at;
    end
  end

  // Shared multiplier: forward step times cos or sin, floored by 2^30.
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  assign mul_b = (state == ST_MUL_X) ? cos_r : sin_r;
  assign prod  = fwd * mul_b;

  // New heading.
  logic signed [31:0] head_next;
  assign head_next = wrap_ang({{2{acc_heading[31]}}, acc_heading} + {{2{dth[31]}}, dth});

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cpm         <= CPM_RESET;
      ws          <= WS_RESET;
      last_left   <= '0;
      last_right  <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
      out_valid   <= 1'b0;
      second      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_COUNTS_PER_METER) cpm <= cfg_data;
        else if (cfg_index == REG_WHEEL_SPACING) ws <= cfg_data;
      end
      // The output state reloads the result register itself when it is taken.
      if (out_valid && !out_stall && state != ST_OUT) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            last_left  <= left_count;
            last_right <= right_count;
            dr         <= dr_in;
            if (right_count != 32'sd0) begin
              mag   <= dl_in[31] ? {1'b0, -dl_in} : {1'b0, dl_in};
              neg   <= dl_in[31];
              dvs   <= (cpm == 32'd0) ? 32'd1 : cpm;
              rem   <= '0;
              quo   <= '0;
              ovf   <= 1'b0;
              cnt   <= CNT_W'(TRV_STEPS - 1);
              state <= ST_DIV_L;
            end else begin
              tl    <= '0;
              tr    <= '0;
              state <= ST_SUM;
            end
          end
        end
        ST_DIV_L, ST_DIV_R: begin
          mag <= {mag[31:0], 1'b0};
          rem <= rem_next;
          quo <= quo_next;
          ovf <= ovf_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            if (state == ST_DIV_L) begin
              tl    <= trv_res;
              mag   <= dr[31] ? {1'b0, -dr} : {1'b0, dr};
              neg   <= dr[31];
              rem   <= '0;
              quo   <= '0;
              ovf   <= 1'b0;
              cnt   <= CNT_W'(TRV_STEPS - 1);
              state <= ST_DIV_R;
            end else begin
              tr    <= trv_res;
              state <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          fwd   <= fwd33[31:0];
          mag   <= diff33[32] ? 33'(-diff33) : 33'(diff33);
          neg   <= diff33[32];
          dvs   <= (ws == 32'd0) ? 32'd1 : ws;
          rem   <= '0;
          quo   <= '0;
          ovf   <= 1'b0;
          cnt   <= CNT_W'(TH_STEPS - 1);
          state <= ST_DIV_TH;
        end
        ST_DIV_TH: begin
          mag <= {mag[31:0], 1'b0};
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            dth    <= wrap_ang(dth_raw);
            second <= 1'b0;
            state  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cx    <= $signed({2'b00, GAIN_Q30});
          cy    <= '0;
          cz    <= z0;
          flip  <= flip0;
          idx   <= '0;
          state <= ST_COR;
        end
        ST_COR: begin
          cx  <= cx_next;
          cy  <= cy_next;
          cz  <= cz_next;
          idx <= idx + 1'b1;
          if (idx == IDX_W'(CORDIC_STEPS - 1)) begin
            cos_r <= clamp_q30(flip ? -cx_next : cx_next);
            sin_r <= clamp_q30(flip ? -cy_next : cy_next);
            state <= second ? ST_OUT : ST_MUL_X;
          end
        end
        ST_MUL_X: begin
          prod_r <= prod[61:30];
          state  <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          acc_x  <= acc_x + prod_r;
          prod_r <= prod[61:30];
          state  <= ST_ADD_Y;
        end
        ST_ADD_Y: begin
          acc_y       <= acc_y + prod_r;
          acc_heading <= head_next;
          second      <= 1'b1;
          state       <= ST_LOAD;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            pos_x     <= acc_x;
            pos_y     <= acc_y;
            heading   <= acc_heading;
            quat_z    <= sin_r;
            quat_w    <= cos_r;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and the pose values.
  `ODO_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall)
  `ODO_ASSERT(a_heading_range, out_valid |-> (heading <= $signed(PI_Q) && heading >= -$signed(PI_Q)))
  `ODO_ASSERT(a_quat_range, out_valid |-> (quat_w <= $signed(ONE_Q30) && quat_w >= -$signed(ONE_Q30)))
  `ODO_ASSERT(a_cordic_index, (state == ST_COR) |-> (idx <= IDX_W'(CORDIC_STEPS - 1)))
  `ODO_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE && !out_valid))

endmodule
